@@ sv/sapt_pkg.sv @@
package sapt_pkg;

	localparam int DEFAULT_SLOT_COUNT = 8;
	localparam logic [7:0] MIN_PACKET_BYTES = 8'd5;
	localparam logic [7:0] BYTE_COUNT_MAX = 8'hFF;

	// request kinds on the input channel
	localparam logic REQ_PAYLOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// object ids
	localparam logic [2:0] ID_SEQ = 3'd0;
	localparam logic [2:0] ID_BATT = 3'd1;
	localparam logic [2:0] ID_TEMP = 3'd2;
	localparam logic [2:0] ID_HUM = 3'd3;
	localparam logic [2:0] ID_PRESS = 3'd4;
	localparam logic [7:0] ID_LAST = 8'd4;

	// result status codes
	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_PARSE_ERR = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_DUP = 3'd3;
	localparam logic [2:0] ST_READ_OK = 3'd4;
	localparam logic [2:0] ST_READ_EMPTY = 3'd5;

	// what the parser hands to the slot table
	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_BAD = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [47:0] source_address;
		logic [31:0] timestamp_ms;
		logic [7:0]  read_slot;
	} item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         slot_index;
		logic [47:0]        stored_address;
		logic [7:0]         seq_num;
		logic [7:0]         batt_pct;
		logic signed [15:0] temperature_raw;
		logic [15:0]        hum_raw;
		logic [23:0]        press_raw;
		logic [31:0]        update_time;
	} result_t;

	typedef struct packed {
		logic [7:0]  pid;
		logic [7:0]  batt;
		logic [15:0] temp;
		logic [15:0] hum;
		logic [23:0] press;
	} reading_t;

	typedef struct packed {
		logic [47:0] address;
		reading_t    reading;
		logic [31:0] update_time;
	} record_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] address;
		logic [31:0] timestamp;
		logic [7:0]  read_slot;
		reading_t    reading;
	} parsed_t;

	// value bytes that follow each object id
	function automatic logic [1:0] obj_len(input logic [2:0] kind);
		logic [1:0] len;
		unique case (kind)
			ID_SEQ, ID_BATT: len = 2'd1;
			ID_TEMP, ID_HUM: len = 2'd2;
			ID_PRESS: len = 2'd3;
			default: len = 2'd0;
		endcase
		return len;
	endfunction

endpackage

@@ sv/sapt_item_if.sv @@
interface sapt_item_if;
	logic valid;
	logic ready;
	sapt_pkg::item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ sv/sapt_result_if.sv @@
interface sapt_result_if;
	logic valid;
	logic ready;
	sapt_pkg::result_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ sv/sapt_parser.sv @@
module sapt_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              en1,
	input  sapt_pkg::item_t   item,
	output logic              v_s1,
	output sapt_pkg::parsed_t parsed_s1
);

	logic [7:0]         cnt_q, cnt_n;
	logic [2:0]         kind_q, kind_n;
	logic [1:0]         left_q, left_n;
	logic               bad_q, bad_n;
	sapt_pkg::reading_t fields_q, fields_n;
	logic [1:0]         pos;
	logic [7:0]         b;
	logic               is_read;
	logic               err;
	logic               emits;
	sapt_pkg::parsed_t  parsed_n;

	assign b = item.data_byte;
	assign is_read = (item.req_type == sapt_pkg::REQ_READ);

	always_comb begin
		kind_n = kind_q;
		left_n = left_q;
		bad_n = bad_q;
		fields_n = fields_q;
		pos = sapt_pkg::obj_len(kind_q) - left_q;
		// the first payload byte is device info: skip it
		if (cnt_q != 8'd0 && !bad_q) begin
			if (left_q == 2'd0) begin
				if (b > sapt_pkg::ID_LAST) begin
					bad_n = 1'b1;
				end else begin
					kind_n = b[2:0];
					left_n = sapt_pkg::obj_len(b[2:0]);
					unique case (b[2:0])
						sapt_pkg::ID_SEQ: fields_n.pid = '0;
						sapt_pkg::ID_BATT: fields_n.batt = '0;
						sapt_pkg::ID_TEMP: fields_n.temp = '0;
						sapt_pkg::ID_HUM: fields_n.hum = '0;
						default: fields_n.press = '0;
					endcase
				end
			end else begin
				unique case (kind_q)
					sapt_pkg::ID_SEQ: fields_n.pid = b;
					sapt_pkg::ID_BATT: fields_n.batt = b;
					sapt_pkg::ID_TEMP:
						fields_n.temp = fields_q.temp | (16'(b) << {pos[0], 3'b000});
					sapt_pkg::ID_HUM:
						fields_n.hum = fields_q.hum | (16'(b) << {pos[0], 3'b000});
					default:
						fields_n.press = fields_q.press | (24'(b) << {pos, 3'b000});
				endcase
				left_n = left_q - 2'd1;
			end
		end
		cnt_n = (cnt_q == sapt_pkg::BYTE_COUNT_MAX) ? cnt_q : cnt_q + 8'd1;
		err = (cnt_n < sapt_pkg::MIN_PACKET_BYTES) || bad_n || (left_n != 2'd0);
		emits = is_read || item.last_byte;

		parsed_n.address = item.source_address;
		parsed_n.timestamp = item.timestamp_ms;
		parsed_n.read_slot = item.read_slot;
		parsed_n.reading = fields_n;
		if (is_read) begin
			parsed_n.op = sapt_pkg::OP_READ;
		end else if (err) begin
			parsed_n.op = sapt_pkg::OP_BAD;
		end else begin
			parsed_n.op = sapt_pkg::OP_STORE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			kind_q <= '0;
			left_q <= '0;
			bad_q <= 1'b0;
			fields_q <= '0;
		end else if (accept && !is_read) begin
			if (item.last_byte) begin
				// packet done: start the next one clean
				cnt_q <= '0;
				kind_q <= '0;
				left_q <= '0;
				bad_q <= 1'b0;
				fields_q <= '0;
			end else begin
				cnt_q <= cnt_n;
				kind_q <= kind_n;
				left_q <= left_n;
				bad_q <= bad_n;
				fields_q <= fields_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && emits;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			parsed_s1 <= parsed_n;
		end
	end

endmodule

@@ sv/sapt_table.sv @@
module sapt_table #(
	parameter int SLOT_COUNT = sapt_pkg::DEFAULT_SLOT_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              v_s1,
	input  sapt_pkg::parsed_t parsed_s1,
	input  logic              en2,
	output logic              v_s2,
	output sapt_pkg::result_t result
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [SLOT_COUNT-1:0] valid_q;
	logic [47:0]           addr_q [SLOT_COUNT];
	logic [7:0]            pid_q [SLOT_COUNT];
	sapt_pkg::record_t     mem [SLOT_COUNT];

	logic [SLOT_COUNT-1:0] match_vec;
	logic [SLOT_COUNT-1:0] dup_vec;
	logic                  found;
	logic                  has_free;
	logic                  dup;
	logic [SLOT_W-1:0]     match_idx;
	logic [SLOT_W-1:0]     free_idx;
	logic [SLOT_W-1:0]     wr_idx;
	logic [SLOT_W-1:0]     rs_idx;
	logic [SLOT_W-1:0]     rd_idx;
	logic                  rs_ok;
	logic                  wr_en;
	logic                  wr_go;
	logic [2:0]            st_n;
	logic [2:0]            idx_n;
	logic                  from_mem_n;
	sapt_pkg::record_t     data_n;
	sapt_pkg::record_t     new_rec;

	logic [2:0]            st_s2;
	logic [2:0]            idx_s2;
	logic                  from_mem_s2;
	sapt_pkg::record_t     data_s2;
	sapt_pkg::record_t     rd_data_s2;
	sapt_pkg::record_t     out_rec;

	// compare the sender against every slot at once
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			match_vec[i] = valid_q[i] && (addr_q[i] == parsed_s1.address);
			dup_vec[i] = match_vec[i] && (pid_q[i] == parsed_s1.reading.pid);
		end
		match_idx = '0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (match_vec[i]) match_idx = SLOT_W'(i);
			if (!valid_q[i]) free_idx = SLOT_W'(i);
		end
	end

	assign found = |match_vec;
	assign dup = |dup_vec;
	assign has_free = ~&valid_q;
	assign wr_idx = found ? match_idx : free_idx;
	assign rs_idx = parsed_s1.read_slot[SLOT_W-1:0];
	assign rs_ok = ({1'b0, parsed_s1.read_slot} < 9'(SLOT_COUNT)) && valid_q[rs_idx];

	assign new_rec.address = parsed_s1.address;
	assign new_rec.reading = parsed_s1.reading;
	assign new_rec.update_time = parsed_s1.timestamp;

	always_comb begin
		wr_en = 1'b0;
		st_n = sapt_pkg::ST_PARSE_ERR;
		idx_n = '0;
		data_n = '0;
		from_mem_n = 1'b0;
		rd_idx = match_idx;
		unique case (parsed_s1.op)
			sapt_pkg::OP_READ: begin
				rd_idx = rs_idx;
				if (rs_ok) begin
					st_n = sapt_pkg::ST_READ_OK;
					idx_n = 3'(rs_idx);
					from_mem_n = 1'b1;
				end else begin
					st_n = sapt_pkg::ST_READ_EMPTY;
					idx_n = parsed_s1.read_slot[2:0];
				end
			end
			sapt_pkg::OP_STORE: begin
				if (!found && !has_free) begin
					st_n = sapt_pkg::ST_FULL;
				end else if (dup) begin
					// drop the repeat, report what is held
					st_n = sapt_pkg::ST_DUP;
					idx_n = 3'(match_idx);
					from_mem_n = 1'b1;
				end else begin
					st_n = sapt_pkg::ST_STORED;
					idx_n = 3'(wr_idx);
					data_n = new_rec;
					wr_en = 1'b1;
				end
			end
			default: begin
				st_n = sapt_pkg::ST_PARSE_ERR;
			end
		endcase
	end

	assign wr_go = v_s1 && en2 && wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_go) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			addr_q[wr_idx] <= parsed_s1.address;
			pid_q[wr_idx] <= parsed_s1.reading.pid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[wr_idx] <= new_rec;
		end
		if (en2) begin
			rd_data_s2 <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			st_s2 <= st_n;
			idx_s2 <= idx_n;
			from_mem_s2 <= from_mem_n;
			data_s2 <= data_n;
		end
	end

	assign out_rec = from_mem_s2 ? rd_data_s2 : data_s2;

	assign result.status = st_s2;
	assign result.slot_index = idx_s2;
	assign result.stored_address = out_rec.address;
	assign result.seq_num = out_rec.reading.pid;
	assign result.batt_pct = out_rec.reading.batt;
	assign result.temperature_raw = $signed(out_rec.reading.temp);
	assign result.hum_raw = out_rec.reading.hum;
	assign result.press_raw = out_rec.reading.press;
	assign result.update_time = out_rec.update_time;

`ifndef SYNTHESIS
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(valid_q) & ~valid_q) == '0)
		else $error("slot valid bit cleared");

	a_write_marks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		wr_go |=> valid_q[$past(wr_idx)])
		else $error("stored slot not marked valid");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && st_s2 == sapt_pkg::ST_FULL) |-> (&valid_q))
		else $error("table full reported with a free slot");

	a_mem_source: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && from_mem_s2) |->
		(st_s2 == sapt_pkg::ST_READ_OK || st_s2 == sapt_pkg::ST_DUP))
		else $error("slot contents returned with wrong status");
`endif

endmodule

@@ sv/sensor_advert_parse_and_table_unit.sv @@
// Parses sensor advertisement service data one byte per transaction and keeps
// the latest readings per sender in a slot table. A payload byte or a read
// request is accepted every cycle while results drain; the byte marked last,
// and every read, give one result, which passes the first and then the second
// register stage. The first holds the byte parser and the finished packet;
// the second compares the sender against all SLOT_COUNT stored addresses in
// parallel, updates the table, and reads slot contents from the record memory
// (read on each advance, write per stored packet). Stall on the result side
// backs up through the two stages, and ready drops only when both are full.
module sensor_advert_parse_and_table_unit #(
	parameter int SLOT_COUNT = sapt_pkg::DEFAULT_SLOT_COUNT
) (
	input  logic          clk,
	input  logic          arst_n,
	sapt_item_if.sink     item,
	sapt_result_if.source result
);

	logic              en1;
	logic              en2;
	logic              accept;
	logic              v_s1;
	logic              v_s2;
	sapt_pkg::parsed_t parsed_s1;

	// advance each stage when it is empty or the one after it moves
	assign en2 = !v_s2 || result.ready;
	assign en1 = !v_s1 || en2;
	assign item.ready = en1;
	assign accept = item.valid && en1;
	assign result.valid = v_s2;

	sapt_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.en1       (en1),
		.item      (item.payload),
		.v_s1      (v_s1),
		.parsed_s1 (parsed_s1)
	);

	sapt_table #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.parsed_s1 (parsed_s1),
		.en2       (en2),
		.v_s2      (v_s2),
		.result    (result.payload)
	);

endmodule
